### rtl/range_coder_encoder_defines.svh
// ---------------------------------------------------------------------------
// Range coder encoder assertion macros
// Shared property shapes for the checker, clocked on clk_i, held off in reset.
// ---------------------------------------------------------------------------
`ifndef RANGE_CODER_ENCODER_DEFINES_SVH
`define RANGE_CODER_ENCODER_DEFINES_SVH

// same-cycle implication
`define RCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rce_pkg.sv
// ---------------------------------------------------------------------------
// Range coder encoder package
// Beat types, job classification codes and coder constants.
// ---------------------------------------------------------------------------
package rce_pkg;

  localparam int unsigned FREQ_BITS   = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MAX_EMIT    = 8;
  localparam int unsigned EMIT_W      = $clog2(MAX_EMIT);

  localparam logic [FREQ_BITS:0] FREQ_MAX  = (FREQ_BITS + 1)'((1 << FREQ_BITS) - 1);
  localparam logic [31:0]        RANGE_TOP = 32'h0100_0000;
  localparam logic [31:0]        RANGE_RST = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_ENCODE,
    KIND_FLUSH,
    KIND_ERROR
  } job_kind_e;

  typedef struct packed {
    logic        command;
    logic [15:0] cum_freq;
    logic [15:0] sym_freq;
    logic [15:0] total_freq;
  } enc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       error;
  } enc_out_t;

  typedef struct packed {
    job_kind_e   kind;
    logic [15:0] cum_freq;
    logic [15:0] sym_freq;
    logic [15:0] total_freq;
  } job_t;

endpackage

### rtl/rce_front.sv
// ---------------------------------------------------------------------------
// Range coder encoder front end
// Accepts input beats, classifies them and holds them in a short job queue.
// ---------------------------------------------------------------------------
module rce_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rce_pkg::enc_in_t in_data_i,
  output logic             job_valid_o,
  input  logic             job_pop_i,
  output rce_pkg::job_t    job_o
);
  import rce_pkg::*;

  job_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop, bad_freq;
  logic [16:0]       span;
  job_t              job_new;

  assign in_stall_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign job_valid_o = (count_q != '0);
  assign job_o       = queue_q[rd_ptr_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = job_pop_i && job_valid_o;

  assign span     = {1'b0, in_data_i.cum_freq} + {1'b0, in_data_i.sym_freq};
  assign bad_freq = (in_data_i.total_freq == '0) || (in_data_i.sym_freq == '0) ||
                    ({1'b0, in_data_i.total_freq} > FREQ_MAX) ||
                    (span > {1'b0, in_data_i.total_freq});

  always_comb begin
    job_new.cum_freq   = in_data_i.cum_freq;
    job_new.sym_freq   = in_data_i.sym_freq;
    job_new.total_freq = in_data_i.total_freq;
    if (in_data_i.command) begin
      job_new.kind = KIND_FLUSH;
    end else if (bad_freq) begin
      job_new.kind = KIND_ERROR;
    end else begin
      job_new.kind = KIND_ENCODE;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= job_new;
    end
  end

endmodule

### rtl/rce_back.sv
// ---------------------------------------------------------------------------
// Range coder encoder back end
// Runs one job at a time: encode jobs divide bit-serially, multiply, add, then output
// ---------------------------------------------------------------------------
module rce_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_pop_o,
  input  rce_pkg::job_t     job_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rce_pkg::enc_out_t out_data_o
);
  import rce_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_ADD    = 3'd3;
  localparam logic [2:0] ST_RENORM = 3'd4;
  localparam logic [2:0] ST_FLUSH  = 3'd5;
  localparam logic [2:0] ST_ERROR  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [63:0]       low_q, low_d;
  logic [31:0]       range_q, range_d;
  logic [EMIT_W-1:0] n_q, n_d;
  logic [4:0]        bit_q, bit_d;
  logic              out_valid_q, out_valid_d;
  enc_out_t          out_data_q, out_data_d;

  job_t              job_q, job_d;
  logic [31:0]       dvd_q, dvd_d;
  logic [15:0]       rem_q, rem_d;
  logic [47:0]       pcum_q, pcum_d;
  logic [31:0]       prng_q, prng_d;

  logic [16:0]       rem_sh, rem_sub;
  logic              rem_ge;
  logic [63:0]       low_sum;
  logic [31:0]       rg_trim, rg_shift;
  logic              more, out_free, emit;
  enc_out_t          emit_data;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign job_pop_o   = (state_q == ST_IDLE) && job_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign rem_sh  = {rem_q, dvd_q[31]};
  assign rem_sub = rem_sh - {1'b0, job_q.total_freq};
  assign rem_ge  = (rem_sh >= {1'b0, job_q.total_freq});

  assign low_sum  = low_q + {32'b0, range_q};
  assign rg_trim  = (low_sum[63:56] != low_q[63:56]) ? {8'b0, ~low_q[23:0]} : range_q;
  assign rg_shift = {rg_trim[23:0], 8'b0};
  assign more     = (rg_shift < RANGE_TOP) && (n_q != EMIT_W'(MAX_EMIT - 1));

  always_comb begin
    state_d   = state_q;
    low_d     = low_q;
    range_d   = range_q;
    n_d       = n_q;
    bit_d     = bit_q;
    job_d     = job_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    pcum_d    = pcum_q;
    prng_d    = prng_q;
    emit      = 1'b0;
    emit_data = '0;

    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_d = job_i;
          n_d   = '0;
          bit_d = '0;
          dvd_d = range_q;
          rem_d = '0;
          case (job_i.kind)
            KIND_ENCODE: state_d = ST_DIV;
            KIND_FLUSH:  state_d = ST_FLUSH;
            default:     state_d = ST_ERROR;
          endcase
        end
      end
      ST_DIV: begin
        rem_d = rem_ge ? rem_sub[15:0] : rem_sh[15:0];
        dvd_d = {dvd_q[30:0], rem_ge};
        bit_d = bit_q + 1'b1;
        if (bit_q == 5'd31) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        pcum_d  = {32'b0, job_q.cum_freq} * {16'b0, dvd_q};
        prng_d  = 32'(dvd_q * {16'b0, job_q.sym_freq});
        state_d = ST_ADD;
      end
      ST_ADD: begin
        low_d   = low_q + {16'b0, pcum_q};
        range_d = prng_q;
        state_d = ST_RENORM;
      end
      ST_RENORM: begin
        if (out_free) begin
          emit = 1'b1;
          if (range_q >= RANGE_TOP) begin
            emit_data.last = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            emit_data.out_byte   = low_q[63:56];
            emit_data.byte_valid = 1'b1;
            emit_data.last       = !more;
            low_d                = {low_q[55:0], 8'b0};
            range_d              = rg_shift;
            n_d                  = n_q + 1'b1;
            if (!more) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit                 = 1'b1;
          emit_data.out_byte   = low_q[63:56];
          emit_data.byte_valid = 1'b1;
          n_d                  = n_q + 1'b1;
          low_d                = {low_q[55:0], 8'b0};
          if (n_q == EMIT_W'(MAX_EMIT - 1)) begin
            emit_data.last = 1'b1;
            low_d          = '0;
            range_d        = RANGE_RST;
            state_d        = ST_IDLE;
          end
        end
      end
      ST_ERROR: begin
        if (out_free) begin
          emit            = 1'b1;
          emit_data.last  = 1'b1;
          emit_data.error = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = emit || (out_valid_q && out_stall_i);
    out_data_d  = emit ? emit_data : out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      low_q       <= '0;
      range_q     <= RANGE_RST;
      n_q         <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      range_q     <= range_d;
      n_q         <= n_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    pcum_q     <= pcum_d;
    prng_q     <= prng_d;
    out_data_q <= out_data_d;
  end

endmodule

### rtl/range_coder_encoder.sv
// ---------------------------------------------------------------------------
// Range coder encoder: an encode beat goes through the job queue and the DIV, MUL,
// ADD and RENORM states before its first result; flush and bad-frequency beats
// use the FLUSH or ERROR state. One symbol is coded at a time, two more may queue.
// Async low reset: queue empty, low cleared, range all ones, no output beat.
// ---------------------------------------------------------------------------
module range_coder_encoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rce_pkg::enc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rce_pkg::enc_out_t out_data_o
);
  import rce_pkg::*;

  logic job_valid, job_pop;
  job_t job;

  rce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_pop_i   (job_pop),
    .job_o       (job)
  );

  rce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/rce_checker.sv
// ---------------------------------------------------------------------------
// Range coder encoder checker
// Port-level properties of the input and result beats, bound to the top level.
// ---------------------------------------------------------------------------
`include "range_coder_encoder_defines.svh"

module rce_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input rce_pkg::enc_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input rce_pkg::enc_out_t out_data_o
);

  logic in_wait;
  logic out_wait;
  logic err_beat;
  logic empty_beat;
  logic byte_beat;
  logic byte_zero;

  assign in_wait    = in_valid_i && in_stall_o;
  assign out_wait   = out_valid_o && out_stall_i;
  assign err_beat   = out_valid_o && out_data_o.error;
  assign empty_beat = out_valid_o && !out_data_o.byte_valid;
  assign byte_beat  = out_valid_o && out_data_o.byte_valid;
  assign byte_zero  = (out_data_o.out_byte == 8'h00);

`RCE_ASSERT_NOW(a_error_alone, err_beat, !out_data_o.byte_valid && out_data_o.last, "bad error beat")
`RCE_ASSERT_NOW(a_empty_is_last, empty_beat, out_data_o.last && byte_zero, "bad empty beat")
`RCE_ASSERT_NOW(a_byte_no_error, byte_beat, !out_data_o.error, "byte beat flags error")
`RCE_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(out_data_o), "stalled result changed")
`RCE_ASSERT_NEXT(a_in_hold, in_wait, in_valid_i && $stable(in_data_i), "stalled input changed")

endmodule

bind range_coder_encoder rce_checker u_rce_checker (.*);

### verif/range_coder_encoder_chk.sv
// ---------------------------------------------------------------------------
// Range coder encoder stream checker
// Watches both channels, codes every accepted input beat with its own copy of
// the coder state (64-bit low, 32-bit range) and compares each result beat
// field by field with the oldest expected byte. Reports failures and the
// number of result beats still due.
// ---------------------------------------------------------------------------
module range_coder_encoder_chk (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  rce_pkg::enc_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  rce_pkg::enc_out_t out_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import rce_pkg::*;

  localparam logic CMD_FLUSH = 1'b1;

  logic [63:0] coded_low;
  logic [31:0] coded_range;
  enc_out_t    due_bytes[$];
  enc_out_t    oldest;
  int          fails;

  task automatic queue_byte(input logic [7:0] value, input logic valid, input logic fin,
                            input logic err);
    enc_out_t r;
    r.out_byte   = value;
    r.byte_valid = valid;
    r.last       = fin;
    r.error      = err;
    due_bytes.push_back(r);
  endtask

  task automatic code_beat(input enc_in_t beat);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [31:0] rg;
    logic [31:0] slice;
    logic [16:0] span;
    int          n;
    n    = 0;
    span = {1'b0, beat.cum_freq} + {1'b0, beat.sym_freq};
    if (beat.command == CMD_FLUSH) begin
      lo = coded_low;
      for (int i = 0; i < 8; i++) begin
        queue_byte(lo[63:56], 1'b1, i == 7, 1'b0);
        lo = lo << 8;
      end
      coded_low   = '0;
      coded_range = RANGE_RST;
    end else if (beat.total_freq == 16'h0 || beat.sym_freq == 16'h0 ||
                 {1'b0, beat.total_freq} > FREQ_MAX ||
                 span > {1'b0, beat.total_freq}) begin
      queue_byte(8'h00, 1'b0, 1'b1, 1'b1);
    end else begin
      slice = coded_range / {16'h0, beat.total_freq};
      lo    = coded_low + {48'h0, beat.cum_freq} * {32'h0, slice};
      rg    = slice * {16'h0, beat.sym_freq};
      while (rg < RANGE_TOP && n < MAX_EMIT) begin
        hi = lo + {32'h0, rg};
        if (lo[63:56] != hi[63:56]) begin
          rg = (lo[31:0] | (RANGE_TOP - 32'd1)) - lo[31:0];
        end
        queue_byte(lo[63:56], 1'b1, 1'b0, 1'b0);
        n++;
        rg = rg << 8;
        lo = lo << 8;
      end
      coded_low   = lo;
      coded_range = rg;
      if (n == 0) begin
        queue_byte(8'h00, 1'b0, 1'b1, 1'b0);
      end else begin
        due_bytes[due_bytes.size() - 1].last = 1'b1;
      end
    end
  endtask

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coded_low   = '0;
      coded_range = RANGE_RST;
      due_bytes.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_bytes.size() == 0) begin
          $error("out_byte expected no beat got %0h", out_data_i.out_byte);
          fails++;
        end else begin
          oldest = due_bytes.pop_front();
          compare_field("out_byte", oldest.out_byte, out_data_i.out_byte);
          compare_field("byte_valid", {7'h0, oldest.byte_valid}, {7'h0, out_data_i.byte_valid});
          compare_field("last", {7'h0, oldest.last}, {7'h0, out_data_i.last});
          compare_field("error", {7'h0, oldest.error}, {7'h0, out_data_i.error});
        end
      end
      if (in_valid_i && !in_stall_i) begin
        code_beat(in_data_i);
      end
      pending_o    <= due_bytes.size();
      fail_count_o <= fails;
    end
  end

endmodule

### verif/range_coder_encoder_tb.sv
// ---------------------------------------------------------------------------
// Range coder encoder testbench
// Drives directed symbols (frequency extremes, bad frequencies, flushes, long
// runs of narrow symbols) and then random symbol streams under four
// idle/stall mixes, while the stream checker predicts and compares.
// ---------------------------------------------------------------------------
module range_coder_encoder_tb;
  import rce_pkg::*;

  localparam logic CMD_ENCODE   = 1'b0;
  localparam logic CMD_FLUSH    = 1'b1;
  localparam int   RANDOM_BEATS = 148;
  localparam int   CYCLE_LIMIT  = 300000;
  localparam int   DRAIN_CYCLES = 48;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  enc_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  enc_out_t out_data;
  int       fail_count;
  int       pending;
  int       idle_pct  = 0;
  int       stall_pct = 0;
  int       cycles    = 0;

  range_coder_encoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  range_coder_encoder_chk chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("range_coder_encoder_tb: errors");
      $finish;
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic enc_in_t symbol(input logic cmd, input logic [15:0] cum,
                                     input logic [15:0] frq, input logic [15:0] tot);
    enc_in_t b;
    b.command    = cmd;
    b.cum_freq   = cum;
    b.sym_freq   = frq;
    b.total_freq = tot;
    return b;
  endfunction

  function automatic enc_in_t random_symbol();
    int      pick;
    int      tot;
    int      frq;
    enc_in_t b;
    pick = $urandom_range(99);
    if (pick < 8) begin
      b = symbol(CMD_FLUSH, 16'($urandom()), 16'($urandom()), 16'($urandom()));
    end else if (pick < 18) begin
      b = symbol(CMD_ENCODE, 16'($urandom()), 16'($urandom()), 16'($urandom()));
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: tot = $urandom_range(64, 2);
        5, 6, 7:       tot = $urandom_range(4096, 65);
        default:       tot = $urandom_range(65535, 4097);
      endcase
      frq = ($urandom_range(3) == 0) ? 1 : $urandom_range(tot, 1);
      b = symbol(CMD_ENCODE, 16'($urandom_range(tot - frq, 0)), 16'(frq), 16'(tot));
    end
    return b;
  endfunction

  task automatic send_beat(input enc_in_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(symbol(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000));
    send_beat(symbol(CMD_ENCODE, 16'h0000, 16'h0001, 16'hFFFF));
    send_beat(symbol(CMD_ENCODE, 16'hFFFE, 16'h0001, 16'hFFFF));
    send_beat(symbol(CMD_ENCODE, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_beat(symbol(CMD_ENCODE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(symbol(CMD_ENCODE, 16'h0000, 16'h0001, 16'h0000));
    send_beat(symbol(CMD_ENCODE, 16'h0001, 16'h0000, 16'h0005));
    send_beat(symbol(CMD_ENCODE, 16'h0001, 16'hFFFF, 16'hFFFF));
    send_beat(symbol(CMD_ENCODE, 16'h8000, 16'h7FFF, 16'hFFFF));
    send_beat(symbol(CMD_ENCODE, 16'h0000, 16'h0001, 16'h0001));
    send_beat(symbol(CMD_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    repeat (8) send_beat(symbol(CMD_ENCODE, 16'hFFFE, 16'h0001, 16'hFFFF));
    repeat (3) send_beat(symbol(CMD_ENCODE, 16'h0001, 16'h0001, 16'h0002));
    send_beat(symbol(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      repeat (RANDOM_BEATS / 4) send_beat(random_symbol());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("range_coder_encoder_tb: clean");
    end else begin
      $display("range_coder_encoder_tb: errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/rce_pkg.sv
rtl/rce_front.sv
rtl/rce_back.sv
rtl/range_coder_encoder.sv
rtl/rce_checker.sv
verif/range_coder_encoder_chk.sv
verif/range_coder_encoder_tb.sv
